// ===== hw/rtl/lsar_pkg.sv =====
package lsar_pkg;

    // Default number of fraction bits of the lux result.
    localparam int LUX_FRAC_BITS_DEF = 8;

    // Field widths.
    localparam int CNT_W    = 16;
    localparam int LUX_OUT_W = 36;
    localparam int STAT_W   = 2;
    localparam int GAIN_W   = 2;
    localparam int TIME_W   = 3;
    localparam int IDX_W    = 3;
    localparam int CFG_W    = 16;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 48;

    // Internal datapath widths, sized for up to 16 fraction bits.
    localparam int DV_W   = 32;
    localparam int Q_W    = 23;
    localparam int QH_W   = 12;
    localparam int REM_W  = 10;
    localparam int X_W    = 25;
    localparam int LUX_W  = 48;
    localparam int MA_W   = 40;
    localparam int MB_W   = 32;
    localparam int P_W    = 64;

    // Step counter and microcode.
    localparam int STEP_W = 5;
    localparam int OP_W   = 4;

    // Largest shift contributions of the gain and time steps.
    localparam int GAIN_SHIFT_MAX = 3;
    localparam int TIME_SHIFT_MAX = 2;

    // Lux = count * 36 / 625 scaled by powers of two.
    localparam int CNT_SCALE  = 36;
    localparam int DIVISOR    = 625;
    localparam int ROUND_HALF = 312;
    localparam int REC_SHIFT  = 40;
    localparam longint RECIP  = (64'd1 << REC_SHIFT) / DIVISOR;

    // The corrected path works on lux with 8 fraction bits at gain 1/8, 25 ms.
    localparam int CORR_SHIFT = 13;
    localparam int CORR_ROUND_BITS = 32;

    // Quartic coefficients (Q.56 for a, b, c and Q.40 for d).
    localparam logic signed [P_W-1:0] CORR_A56 = 64'sd43332;
    localparam logic signed [P_W-1:0] CORR_B56 = 64'sd676793746;
    localparam logic signed [P_W-1:0] CORR_C56 = 64'sd5871829220000;
    localparam logic signed [P_W-1:0] CORR_D40 = 64'sd1102040504520;

    // Register indexes.
    localparam logic [IDX_W-1:0] REG_LOW_THRESHOLD  = 3'd0;
    localparam logic [IDX_W-1:0] REG_HIGH_THRESHOLD = 3'd1;
    localparam logic [IDX_W-1:0] REG_CORR_ENABLE    = 3'd2;
    localparam logic [IDX_W-1:0] REG_START_GAIN     = 3'd3;
    localparam logic [IDX_W-1:0] REG_START_TIME     = 3'd4;

    // Range status codes.
    localparam logic [STAT_W-1:0] STAT_GOOD   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DARK   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BRIGHT = 2'd2;

    // Gain and time step limits.
    localparam logic [GAIN_W-1:0] GAIN_MIN   = 2'd0;
    localparam logic [GAIN_W-1:0] GAIN_1X    = 2'd2;
    localparam logic [GAIN_W-1:0] GAIN_MAX   = 2'd3;
    localparam logic [TIME_W-1:0] TIME_MIN   = 3'd0;
    localparam logic [TIME_W-1:0] TIME_100MS = 3'd2;
    localparam logic [TIME_W-1:0] TIME_MAX   = 3'd5;

    // Datapath operations.
    localparam logic [OP_W-1:0] OP_NOP     = 4'd0;
    localparam logic [OP_W-1:0] OP_DMUL    = 4'd1;
    localparam logic [OP_W-1:0] OP_DEST    = 4'd2;
    localparam logic [OP_W-1:0] OP_DBACK   = 4'd3;
    localparam logic [OP_W-1:0] OP_DFIX    = 4'd4;
    localparam logic [OP_W-1:0] OP_SECOND  = 4'd5;
    localparam logic [OP_W-1:0] OP_COMBINE = 4'd6;
    localparam logic [OP_W-1:0] OP_QMA     = 4'd7;
    localparam logic [OP_W-1:0] OP_QADDB   = 4'd8;
    localparam logic [OP_W-1:0] OP_QMH     = 4'd9;
    localparam logic [OP_W-1:0] OP_QADDC   = 4'd10;
    localparam logic [OP_W-1:0] OP_QMS     = 4'd11;
    localparam logic [OP_W-1:0] OP_QADDD   = 4'd12;
    localparam logic [OP_W-1:0] OP_QROUND  = 4'd13;

    localparam logic [STEP_W-1:0] STEP_DONE = 5'd18;

    // One control word of the microprogram.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              skip;
        logic [STEP_W-1:0] target;
        logic              last;
    } cword_t;

    // Control from the sequencer to the datapath and the top level.
    typedef struct packed {
        logic            start;
        logic [OP_W-1:0] op;
        logic            done;
    } ctrl_t;

    // Microprogram: two divisions by 625, then the optional quartic.
    function automatic cword_t ucode(input logic [STEP_W-1:0] step);
        cword_t cw;
        cw = '{op: OP_NOP, skip: 1'b0, target: '0, last: 1'b0};
        unique case (step)
            5'd0:  cw.op = OP_DMUL;
            5'd1:  cw.op = OP_DEST;
            5'd2:  cw.op = OP_DBACK;
            5'd3:  cw.op = OP_DFIX;
            5'd4:  cw.op = OP_SECOND;
            5'd5:  cw.op = OP_DMUL;
            5'd6:  cw.op = OP_DEST;
            5'd7:  cw.op = OP_DBACK;
            5'd8:  cw.op = OP_DFIX;
            5'd9:
            begin
                cw.op = OP_COMBINE;
                cw.skip = 1'b1;
                cw.target = STEP_DONE;
            end
            5'd10: cw.op = OP_QMA;
            5'd11: cw.op = OP_QADDB;
            5'd12: cw.op = OP_QMH;
            5'd13: cw.op = OP_QADDC;
            5'd14: cw.op = OP_QMS;
            5'd15: cw.op = OP_QADDD;
            5'd16: cw.op = OP_QMS;
            5'd17: cw.op = OP_QROUND;
            default: cw.last = 1'b1;
        endcase
        return cw;
    endfunction

    // Power-of-two exponent contributed by each gain step.
    function automatic int gain_shift(input logic [GAIN_W-1:0] g);
        int s;
        unique case (g)
            2'd0: s = 3;
            2'd1: s = 2;
            2'd2: s = 0;
            2'd3: s = -1;
        endcase
        return s;
    endfunction

    // Power-of-two exponent contributed by each integration step.
    function automatic int time_shift(input logic [TIME_W-1:0] t);
        int s;
        unique case (t)
            3'd0: s = 2;
            3'd1: s = 1;
            3'd2: s = 0;
            3'd3: s = -1;
            3'd4: s = -2;
            default: s = -3;
        endcase
        return s;
    endfunction

endpackage

// ===== hw/rtl/lsar_seq.sv =====
module lsar_seq
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  out_free,
    input  logic                  corr_sel,
    output logic                  busy,
    output lsar_pkg::ctrl_t       ctrl
);

    logic [lsar_pkg::STEP_W-1:0] step_reg;
    logic [lsar_pkg::STEP_W-1:0] step_next;
    logic                        busy_reg;
    logic                        busy_next;
    lsar_pkg::cword_t            cw;

    // Fetch the control word of the current step.
    assign cw = lsar_pkg::ucode(step_reg);
    assign busy = busy_reg;

    // Drive the datapath from the control word.
    always_comb
    begin
        ctrl.start = start;
        ctrl.op    = busy_reg ? cw.op : lsar_pkg::OP_NOP;
        ctrl.done  = busy_reg && cw.last && out_free;
    end

    // Step counter with a conditional jump; the last step waits for the output.
    always_comb
    begin
        step_next = step_reg;
        busy_next = busy_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            if (cw.last)
            begin
                if (out_free)
                begin
                    busy_next = 1'b0;
                end
            end
            else if (cw.skip && !corr_sel)
            begin
                step_next = cw.target;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

endmodule

// ===== hw/rtl/lsar_dp.sv =====
module lsar_dp
#(
    parameter int LUX_FRAC_BITS = lsar_pkg::LUX_FRAC_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  lsar_pkg::ctrl_t                 ctrl,
    input  logic [lsar_pkg::CNT_W-1:0]      count,
    input  logic [lsar_pkg::GAIN_W-1:0]     gain_step,
    input  logic [lsar_pkg::TIME_W-1:0]     time_step,
    input  logic                            corr_enable,
    output logic                            corr_sel,
    output logic [lsar_pkg::LUX_W-1:0]      lux
);

    localparam int SH_MAX = lsar_pkg::GAIN_SHIFT_MAX + lsar_pkg::TIME_SHIFT_MAX + LUX_FRAC_BITS;
    localparam int SH_W   = $clog2(SH_MAX + 1);
    localparam int RSH    = lsar_pkg::CORR_ROUND_BITS - LUX_FRAC_BITS;
    localparam logic [lsar_pkg::P_W-1:0] RND = 64'd1 << (RSH - 1);

    logic [lsar_pkg::DV_W-1:0]           dv_reg;
    logic [lsar_pkg::Q_W-1:0]            q_reg;
    logic [lsar_pkg::QH_W-1:0]           qh_reg;
    logic [lsar_pkg::REM_W-1:0]          r_reg;
    logic [SH_W-1:0]                     sh_reg;
    logic [lsar_pkg::X_W-1:0]            x_reg;
    logic [lsar_pkg::LUX_W-1:0]          lux_reg;
    logic signed [lsar_pkg::P_W-1:0]     p_reg;
    logic signed [lsar_pkg::P_W-1:0]     h_reg;
    logic                                corr_reg;

    logic signed [lsar_pkg::MA_W-1:0]    mul_a;
    logic signed [lsar_pkg::MB_W-1:0]    mul_b;
    logic signed [lsar_pkg::MA_W+lsar_pkg::MB_W-1:0] prod;
    logic signed [lsar_pkg::P_W-1:0]     h_hi;
    logic signed [lsar_pkg::P_W-1:0]     p_lo;
    logic [lsar_pkg::REM_W:0]            rem;
    logic                                rem_big;
    logic [lsar_pkg::LUX_W-1:0]          combined;
    logic [lsar_pkg::P_W-1:0]            y_round;
    int                                  sh_int;
    logic                                sel_now;

    assign corr_sel = corr_reg;
    assign lux      = lux_reg;

    // Shift amount and path choice for the item being loaded.
    always_comb
    begin
        sel_now = corr_enable && (gain_step == lsar_pkg::GAIN_MIN)
                  && (time_step == lsar_pkg::TIME_MIN);
        sh_int = lsar_pkg::gain_shift(gain_step) + lsar_pkg::time_shift(time_step)
                 + LUX_FRAC_BITS;
        if (sel_now)
        begin
            sh_int = lsar_pkg::CORR_SHIFT;
        end
        else if (sh_int < 0)
        begin
            sh_int = 0;
        end
    end

    // Shared signed multiplier with operand selection by operation.
    always_comb
    begin
        h_hi  = h_reg >>> 16;
        mul_a = '0;
        mul_b = '0;
        unique case (ctrl.op)
            lsar_pkg::OP_DMUL:
            begin
                mul_a = $signed(lsar_pkg::MA_W'(dv_reg));
                mul_b = $signed(lsar_pkg::MB_W'(lsar_pkg::RECIP));
            end
            lsar_pkg::OP_DBACK:
            begin
                mul_a = $signed(lsar_pkg::MA_W'(q_reg));
                mul_b = $signed(lsar_pkg::MB_W'(lsar_pkg::DIVISOR));
            end
            lsar_pkg::OP_QMA:
            begin
                mul_a = lsar_pkg::CORR_A56[lsar_pkg::MA_W-1:0];
                mul_b = $signed(lsar_pkg::MB_W'(x_reg));
            end
            lsar_pkg::OP_QMH:
            begin
                mul_a = h_reg[lsar_pkg::MA_W-1:0];
                mul_b = $signed(lsar_pkg::MB_W'(x_reg));
            end
            lsar_pkg::OP_QMS:
            begin
                mul_a = h_hi[lsar_pkg::MA_W-1:0];
                mul_b = $signed(lsar_pkg::MB_W'(x_reg));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = mul_a * mul_b;
    end

    // Remainder check, recombination and final rounding.
    always_comb
    begin
        rem      = dv_reg[lsar_pkg::REM_W:0] - p_reg[lsar_pkg::REM_W:0];
        rem_big  = rem >= (lsar_pkg::REM_W + 1)'(lsar_pkg::DIVISOR);
        combined = (lsar_pkg::LUX_W'(qh_reg) << sh_reg) + lsar_pkg::LUX_W'(q_reg);
        p_lo     = p_reg >>> 8;
        y_round  = $unsigned(p_reg) + RND;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corr_reg <= 1'b0;
        end
        else if (ctrl.start)
        begin
            corr_reg <= sel_now;
        end
    end

    // Datapath registers, one operation per step.
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            dv_reg <= lsar_pkg::DV_W'(count) * lsar_pkg::DV_W'(lsar_pkg::CNT_SCALE);
            sh_reg <= SH_W'(sh_int);
        end
        else
        begin
            unique case (ctrl.op)
                lsar_pkg::OP_DMUL, lsar_pkg::OP_DBACK, lsar_pkg::OP_QMA,
                lsar_pkg::OP_QMH, lsar_pkg::OP_QMS:
                begin
                    p_reg <= prod[lsar_pkg::P_W-1:0];
                end
                lsar_pkg::OP_DEST:
                begin
                    q_reg <= p_reg[lsar_pkg::REC_SHIFT +: lsar_pkg::Q_W];
                end
                lsar_pkg::OP_DFIX:
                begin
                    if (rem_big)
                    begin
                        q_reg <= q_reg + 1'b1;
                        r_reg <= lsar_pkg::REM_W'(rem - (lsar_pkg::REM_W + 1)'(lsar_pkg::DIVISOR));
                    end
                    else
                    begin
                        r_reg <= rem[lsar_pkg::REM_W-1:0];
                    end
                end
                lsar_pkg::OP_SECOND:
                begin
                    qh_reg <= q_reg[lsar_pkg::QH_W-1:0];
                    dv_reg <= (lsar_pkg::DV_W'(r_reg) << sh_reg)
                              + lsar_pkg::DV_W'(lsar_pkg::ROUND_HALF);
                end
                lsar_pkg::OP_COMBINE:
                begin
                    lux_reg <= combined;
                    x_reg   <= combined[lsar_pkg::X_W-1:0];
                end
                lsar_pkg::OP_QADDB:
                begin
                    h_reg <= p_lo - lsar_pkg::CORR_B56;
                end
                lsar_pkg::OP_QADDC:
                begin
                    h_reg <= p_lo + lsar_pkg::CORR_C56;
                end
                lsar_pkg::OP_QADDD:
                begin
                    h_reg <= p_lo + lsar_pkg::CORR_D40;
                end
                lsar_pkg::OP_QROUND:
                begin
                    if (p_reg[lsar_pkg::P_W-1])
                    begin
                        lux_reg <= '0;
                    end
                    else
                    begin
                        lux_reg <= lsar_pkg::LUX_W'(y_round >> RSH);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/light_sensor_auto_range.sv =====
// Ambient light auto-ranging. Each input item carries one raw 16-bit count taken
// at the current gain and integration step; the result item gives lux (unsigned,
// LUX_FRAC_BITS fraction bits, saturated to 36 bits), the range status and the
// gain and time steps to use for the next reading. A short microprogram runs
// the work on one shared multiplier: two divisions by 625 through a reciprocal
// and a remainder fix, and, when correction is enabled at gain 1/8 and 25 ms,
// a quartic evaluated in eight more steps. A new item is not accepted until the
// previous one has passed its result step; the result step holds while a
// previous result is still waiting on the output.
// Writing the start gain or start time register loads the live step at once.
module light_sensor_auto_range
#(
    parameter int LUX_FRAC_BITS = lsar_pkg::LUX_FRAC_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    // raw_count[15:0]
    input  logic [lsar_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // lux_q8[35:0], range_status[37:36], next_gain_step[39:38],
    // next_time_step[42:40], zero[47:43]
    output logic [lsar_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_we,
    input  logic [lsar_pkg::IDX_W-1:0]         cfg_index,
    input  logic [lsar_pkg::CFG_W-1:0]         cfg_data
);

    localparam logic [lsar_pkg::LUX_W-1:0] LUX_SAT = (lsar_pkg::LUX_W'(1) << lsar_pkg::LUX_OUT_W) - 1'b1;

    logic [lsar_pkg::CNT_W-1:0]      low_reg;
    logic [lsar_pkg::CNT_W-1:0]      high_reg;
    logic                            corr_en_reg;
    logic [lsar_pkg::GAIN_W-1:0]     gain_reg;
    logic [lsar_pkg::GAIN_W-1:0]     gain_next;
    logic [lsar_pkg::TIME_W-1:0]     time_reg;
    logic [lsar_pkg::TIME_W-1:0]     time_next;
    logic [lsar_pkg::TIME_W-1:0]     time_wr;
    logic [lsar_pkg::CNT_W-1:0]      cnt_reg;
    logic                            m_tvalid_reg;
    logic [lsar_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    logic                            busy;
    logic                            accept;
    logic                            out_free;
    logic                            corr_sel;
    logic [lsar_pkg::LUX_W-1:0]      lux_wide;
    logic [lsar_pkg::LUX_OUT_W-1:0]  lux_sat;
    logic [lsar_pkg::STAT_W-1:0]     status;
    lsar_pkg::ctrl_t                 ctrl;

    assign s_tready = !busy;
    assign accept   = s_tvalid && !busy;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    lsar_seq u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .out_free (out_free),
        .corr_sel (corr_sel),
        .busy     (busy),
        .ctrl     (ctrl)
    );

    lsar_dp
    #(
        .LUX_FRAC_BITS (LUX_FRAC_BITS)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .count       (s_tdata[lsar_pkg::CNT_W-1:0]),
        .gain_step   (gain_reg),
        .time_step   (time_reg),
        .corr_enable (corr_en_reg),
        .corr_sel    (corr_sel),
        .lux         (lux_wide)
    );

    // Saturate lux to the output field.
    assign lux_sat = (lux_wide > LUX_SAT) ? LUX_SAT[lsar_pkg::LUX_OUT_W-1:0]
                                          : lux_wide[lsar_pkg::LUX_OUT_W-1:0];

    // A start time above 800 ms is held at 800 ms.
    assign time_wr = (cfg_data[lsar_pkg::TIME_W-1:0] > lsar_pkg::TIME_MAX)
                     ? lsar_pkg::TIME_MAX : cfg_data[lsar_pkg::TIME_W-1:0];

    // Range decision: too dark raises sensitivity, too bright lowers it.
    always_comb
    begin
        gain_next = gain_reg;
        time_next = time_reg;
        status    = lsar_pkg::STAT_GOOD;
        if (cnt_reg < low_reg)
        begin
            status = lsar_pkg::STAT_DARK;
            priority if (time_reg < lsar_pkg::TIME_100MS)
            begin
                time_next = time_reg + 1'b1;
            end
            else if (gain_reg < lsar_pkg::GAIN_MAX)
            begin
                gain_next = gain_reg + 1'b1;
            end
            else if (time_reg < lsar_pkg::TIME_MAX)
            begin
                time_next = time_reg + 1'b1;
            end
        end
        else if (cnt_reg > high_reg)
        begin
            status = lsar_pkg::STAT_BRIGHT;
            priority if (time_reg > lsar_pkg::TIME_100MS)
            begin
                time_next = time_reg - 1'b1;
            end
            else if (gain_reg > lsar_pkg::GAIN_MIN)
            begin
                gain_next = gain_reg - 1'b1;
            end
            else if (time_reg > lsar_pkg::TIME_MIN)
            begin
                time_next = time_reg - 1'b1;
            end
        end
    end

    // Configuration registers and the live gain and time steps.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg     <= lsar_pkg::CNT_W'(100);
            high_reg    <= lsar_pkg::CNT_W'(10000);
            corr_en_reg <= 1'b0;
            gain_reg    <= lsar_pkg::GAIN_1X;
            time_reg    <= lsar_pkg::TIME_100MS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lsar_pkg::REG_LOW_THRESHOLD:  low_reg     <= cfg_data;
                lsar_pkg::REG_HIGH_THRESHOLD: high_reg    <= cfg_data;
                lsar_pkg::REG_CORR_ENABLE:    corr_en_reg <= cfg_data[0];
                lsar_pkg::REG_START_GAIN:     gain_reg    <= cfg_data[lsar_pkg::GAIN_W-1:0];
                lsar_pkg::REG_START_TIME:     time_reg    <= time_wr;
                default:
                begin
                end
            endcase
        end
        else if (ctrl.done)
        begin
            gain_reg <= gain_next;
            time_reg <= time_next;
        end
    end

    // Count held for the range decision.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cnt_reg <= s_tdata[lsar_pkg::CNT_W-1:0];
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (ctrl.done)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.done)
        begin
            m_tdata_reg <= {5'b0, time_next, gain_next, status, lux_sat};
        end
    end

endmodule
